// ===== design/sha1h_pkg.sv =====
// Shared constants and helpers for the short-message SHA-1 hash block.
package sha1h_pkg;

  localparam int MAX_MESSAGE_BYTES_DEF = 20;  // message storage incl. the marker byte
  localparam int MSG_BYTES             = 20;  // input bytes carried per transaction
  localparam int LEN_W                 = 5;
  localparam int LEN_RESET             = 8;
  localparam int ROUNDS                = 80;
  localparam int RND_W                 = 7;
  localparam int WORD_W                = 32;
  localparam int SCHED_DEPTH           = 16;

  typedef logic [WORD_W-1:0] word_t;

  localparam word_t H_INIT0 = 32'h6745_2301;
  localparam word_t H_INIT1 = 32'hefcd_ab89;
  localparam word_t H_INIT2 = 32'h98ba_dcfe;
  localparam word_t H_INIT3 = 32'h1032_5476;
  localparam word_t H_INIT4 = 32'hc3d2_e1f0;

  localparam word_t K_0 = 32'h5a82_7999;
  localparam word_t K_1 = 32'h6ed9_eba1;
  localparam word_t K_2 = 32'h8f1b_bcdc;
  localparam word_t K_3 = 32'hca62_c1d6;

  // Round phase, one per group of twenty rounds
  localparam logic [1:0] PH_CH     = 2'd0;
  localparam logic [1:0] PH_PAR0   = 2'd1;
  localparam logic [1:0] PH_MAJ    = 2'd2;
  localparam logic [1:0] PH_PAR1   = 2'd3;

  function automatic word_t bswap32(input word_t x);
    bswap32 = {x[7:0], x[15:8], x[23:16], x[31:24]};
  endfunction

endpackage

// ===== design/sha1_short_message_hash.sv =====
// Top level: single-block SHA-1 of a short message, one round per clock.
//
// Computes the standard SHA-1 digest of a message of 0 to MAX_MESSAGE_BYTES-1
// bytes. The message length comes from the cfg port (reset 8, values above
// MAX_MESSAGE_BYTES-1 saturate). Bytes at and beyond the length are dropped
// and replaced by the 0x80 pad marker followed by zeros; the bit length goes
// in the last block word. One input transaction yields one output transaction
// holding the five digest words, each byte-reversed so that digest byte 4*j
// sits in bits 7:0 of word j. Sequence: the input is taken in the idle state,
// then one shared round datapath (5-input adder, f mux, 16-word message
// schedule shift line) runs the 80 rounds at one per cycle, then a final step
// adds the initial values into the output register. in_tready drops after the
// accept edge and stays low through the round and final steps; out_tvalid
// rises once the final step has loaded the output register.
// The result waits in the output register, so the next message can be
// accepted while the previous digest is still pending; the core stalls in its
// final step only if the output register is still full when the next digest
// is ready.
module sha1_short_message_hash
  import sha1h_pkg::*;
#(
  parameter int MAX_MESSAGE_BYTES = MAX_MESSAGE_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  // config: message_length
  input  logic               cfg_we,
  input  logic [LEN_W-1:0]   cfg_wdata,
  // input: bytes_low [63:0], bytes_mid [127:64], bytes_high [159:128]
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [159:0]       in_tdata,
  // output: digest_h0 [31:0], digest_h1 [63:32], digest_h2 [95:64],
  //         digest_h3 [127:96], digest_h4 [159:128]
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [159:0]       out_tdata
);

  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_MESSAGE_BYTES - 1);
  localparam logic [LEN_W-1:0] LEN_RST =
    (LEN_RESET > MAX_MESSAGE_BYTES - 1) ? LEN_MAX : LEN_W'(LEN_RESET);
  localparam logic [RND_W-1:0] RND_LAST = RND_W'(ROUNDS - 1);

  // sequencer states
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ROUND = 2'd1;
  localparam logic [1:0] ST_FINAL = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [RND_W-1:0] rnd_r, rnd_nxt;
  logic [LEN_W-1:0] len_r;
  logic             out_valid_r, out_valid_nxt;
  logic [159:0]     out_data_r;

  word_t a_r, b_r, c_r, d_r, e_r;
  word_t w_r [SCHED_DEPTH];

  // ---------------------------------------------------------------------------
  // Length register, saturated on write
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= LEN_RST;
    end else if (cfg_we) begin
      len_r <= (cfg_wdata > LEN_MAX) ? LEN_MAX : cfg_wdata;
    end
  end

  // ---------------------------------------------------------------------------
  // Padding: keep bytes below the length, marker at the length, zeros after
  // ---------------------------------------------------------------------------
  logic [7:0] msg_byte [MSG_BYTES];
  word_t      blk_word [MSG_BYTES/4];

  always_comb begin
    for (int i = 0; i < MSG_BYTES; i++) begin
      if (LEN_W'(i) < len_r) begin
        msg_byte[i] = in_tdata[8*i +: 8];
      end else if (LEN_W'(i) == len_r) begin
        msg_byte[i] = 8'h80;
      end else begin
        msg_byte[i] = 8'h00;
      end
    end
    // big-endian word packing
    for (int k = 0; k < MSG_BYTES/4; k++) begin
      blk_word[k] = {msg_byte[4*k], msg_byte[4*k+1], msg_byte[4*k+2], msg_byte[4*k+3]};
    end
  end

  // ---------------------------------------------------------------------------
  // Round datapath
  // ---------------------------------------------------------------------------
  logic [1:0] phase;
  word_t      f_val, k_val, t_val, w_new;

  always_comb begin
    if (rnd_r < RND_W'(20)) begin
      phase = PH_CH;
    end else if (rnd_r < RND_W'(40)) begin
      phase = PH_PAR0;
    end else if (rnd_r < RND_W'(60)) begin
      phase = PH_MAJ;
    end else begin
      phase = PH_PAR1;
    end

    case (phase)
      PH_CH: begin
        f_val = (b_r & c_r) | (~b_r & d_r);
        k_val = K_0;
      end
      PH_PAR0: begin
        f_val = b_r ^ c_r ^ d_r;
        k_val = K_1;
      end
      PH_MAJ: begin
        f_val = (b_r & c_r) | (b_r & d_r) | (c_r & d_r);
        k_val = K_2;
      end
      default: begin
        f_val = b_r ^ c_r ^ d_r;
        k_val = K_3;
      end
    endcase

    t_val = {a_r[26:0], a_r[31:27]} + f_val + e_r + k_val + w_r[0];

    // schedule: w[i+16] from w[i+13], w[i+8], w[i+2], w[i]
    w_new = w_r[13] ^ w_r[8] ^ w_r[2] ^ w_r[0];
    w_new = {w_new[30:0], w_new[31]};
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  logic out_free;
  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt     = state_r;
    rnd_nxt       = rnd_r;
    out_valid_nxt = out_valid_r && !out_tready;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = ST_ROUND;
          rnd_nxt   = '0;
        end
      end
      ST_ROUND: begin
        if (rnd_r == RND_LAST) begin
          state_nxt = ST_FINAL;
        end else begin
          rnd_nxt = rnd_r + RND_W'(1);
        end
      end
      ST_FINAL: begin
        if (out_free) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rnd_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rnd_r       <= rnd_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // working variables and schedule
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_tvalid) begin
      a_r <= H_INIT0;
      b_r <= H_INIT1;
      c_r <= H_INIT2;
      d_r <= H_INIT3;
      e_r <= H_INIT4;
      for (int k = 0; k < SCHED_DEPTH; k++) begin
        if (k < MSG_BYTES/4) begin
          w_r[k] <= blk_word[k];
        end else if (k == SCHED_DEPTH - 1) begin
          w_r[k] <= {24'h0, len_r, 3'b000};  // bit length
        end else begin
          w_r[k] <= '0;
        end
      end
    end else if (state_r == ST_ROUND) begin
      a_r <= t_val;
      b_r <= a_r;
      c_r <= {b_r[1:0], b_r[31:2]};
      d_r <= c_r;
      e_r <= d_r;
      for (int k = 0; k < SCHED_DEPTH - 1; k++) begin
        w_r[k] <= w_r[k+1];
      end
      w_r[SCHED_DEPTH-1] <= w_new;
    end
  end

  // final feed-forward into the output register
  always_ff @(posedge clk) begin
    if (state_r == ST_FINAL && out_free) begin
      out_data_r <= {bswap32(H_INIT4 + e_r), bswap32(H_INIT3 + d_r), bswap32(H_INIT2 + c_r),
                     bswap32(H_INIT1 + b_r), bswap32(H_INIT0 + a_r)};
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== sim/sha1_short_message_hash_tb.sv =====
// Self-checking testbench for the short-message SHA-1 hash block.
module sha1_short_message_hash_tb
  import sha1h_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // Each transaction costs one full hash in the core plus idle gaps, and the
  // timeout below leaves a wide margin over the whole run.
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 100;   // a bit more than one full hash
  localparam int RAND_PHASES  = 15;
  localparam int PHASE_ITEMS  = 40;
  localparam int LAST_LEN     = MAX_MESSAGE_BYTES_DEF - 1;

  logic               clk;
  logic               rst_n      = 1'b0;
  logic               cfg_we     = 1'b0;
  logic [LEN_W-1:0]   cfg_wdata  = '0;
  logic               in_tvalid  = 1'b0;
  logic               in_tready;
  logic [159:0]       in_tdata   = '0;   // bytes_low, bytes_mid, bytes_high
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [159:0]       out_tdata;         // digest_h0 .. digest_h4

  // Testbench copy of the message_length register.
  logic [LEN_W-1:0]   msg_len = LEN_W'(LEN_RESET);

  // Digests expected, oldest first.
  logic [159:0]       digest_q[$];

  int                 mismatch_cnt = 0;
  int                 fail_cnt     = 0;
  bit                 src_idle_en  = 1'b1;
  bit                 sink_idle_en = 1'b1;
  int                 hold_req     = 0;

  sha1_short_message_hash u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("sha1_short_message_hash test failed");
    $finish;
  end

  function automatic word_t rol(input word_t x, input int n);
    rol = (x << n) | (x >> (32 - n));
  endfunction

  // Digest of one message: pad into one 64-byte block, 80 rounds, then pack
  // each state word byte-reversed, word 0 in the low bits.
  function automatic logic [159:0] sha1_digest(input logic [159:0] msg,
                                               input logic [LEN_W-1:0] len_reg);
    logic [7:0]   blk [64];
    word_t        w [80];
    word_t        h [5];
    word_t        a, b, c, d, e, f, k, t;
    logic [15:0]  bit_cnt;
    logic [159:0] res;
    int           n;
    int           i;
    // lengths past the last usable byte saturate
    n = (int'(len_reg) > LAST_LEN) ? LAST_LEN : int'(len_reg);
    for (i = 0; i < 64; i++) blk[i] = 8'h00;
    // bytes at and past the length are dropped, whatever the input holds
    for (i = 0; i < n; i++) blk[i] = msg[8*i +: 8];
    blk[n]  = 8'h80;
    bit_cnt = 16'(n * 8);
    blk[62] = bit_cnt[15:8];
    blk[63] = bit_cnt[7:0];
    for (i = 0; i < 16; i++)
      w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
    for (i = 16; i < 80; i++)
      w[i] = rol(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
    h[0] = H_INIT0; h[1] = H_INIT1; h[2] = H_INIT2; h[3] = H_INIT3; h[4] = H_INIT4;
    a = h[0]; b = h[1]; c = h[2]; d = h[3]; e = h[4];
    for (i = 0; i < 80; i++) begin
      if (i < 20) begin
        f = (b & c) | (~b & d);
        k = K_0;
      end else if (i < 40) begin
        f = b ^ c ^ d;
        k = K_1;
      end else if (i < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = K_2;
      end else begin
        f = b ^ c ^ d;
        k = K_3;
      end
      t = rol(a, 5) + f + e + k + w[i];
      e = d;
      d = c;
      c = rol(b, 30);
      b = a;
      a = t;
    end
    h[0] += a; h[1] += b; h[2] += c; h[3] += d; h[4] += e;
    for (i = 0; i < 5; i++)
      res[32*i +: 32] = {h[i][7:0], h[i][15:8], h[i][23:16], h[i][31:24]};
    return res;
  endfunction

  function automatic logic [159:0] rand_msg();
    return {$urandom, $urandom, $urandom, $urandom, $urandom};
  endfunction

  // Offer one message and hold it until the block takes it. in_tvalid stays
  // high on return so a back-to-back transaction needs no extra toggle.
  task automatic send_message(input logic [159:0] msg);
    if (src_idle_en && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= msg;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    digest_q.push_back(sha1_digest(msg, msg_len));
  endtask

  // Stop offering and wait for every pending digest. Always advances at
  // least one edge so the drop of in_tvalid is never undone in the same step.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (digest_q.size() != 0);
  endtask

  // Register writes happen only with the block idle.
  task automatic set_length(input logic [LEN_W-1:0] len);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= len;
    @(posedge clk);
    cfg_we    <= 1'b0;
    msg_len    = len;
  endtask

  // Reset value of the length (8): garbage past byte 7 must be ignored.
  task automatic test_reset_length();
    send_message('0);
    send_message('1);
    send_message(rand_msg());
  endtask

  // Empty, one byte, the longest message and length 7, with all-ones/zeros and some other content.
  task automatic test_length_extremes();
    set_length(0);
    send_message('1);
    send_message('0);
    set_length(1);
    send_message('1);
    send_message({152'h0, 8'h61});
    set_length(5'(LAST_LEN));
    send_message('1);
    send_message('0);
    send_message(rand_msg());
    set_length(7);
    send_message('1);
  endtask

  // Lengths beyond the last byte behave like the longest one; the top input
  // byte never enters the message.
  task automatic test_saturation();
    set_length(5'(MAX_MESSAGE_BYTES_DEF));
    send_message('1);
    send_message(rand_msg());
    set_length('1);
    send_message('1);
    send_message({8'hff, 152'h0});
  endtask

  // Receiver holds off for a long stretch while messages keep coming, so
  // the output register fills and in_tready stays low; then the sender
  // pauses until everything has drained.
  task automatic test_backpressure();
    set_length(12);
    src_idle_en = 1'b0;
    hold_req    = HOLD_CYCLES;
    repeat (6) send_message(rand_msg());
    wait_drained();
    src_idle_en = 1'b1;
  endtask

  // Random lengths per phase, random content; the last phases run with no
  // idling on either side.
  task automatic test_random_lengths();
    int ph;
    int j;
    for (ph = 0; ph < RAND_PHASES; ph++) begin
      if (ph >= RAND_PHASES - 2) begin
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
      end
      if ($urandom_range(0, 5) == 0)
        set_length(5'($urandom_range(MAX_MESSAGE_BYTES_DEF, 31)));
      else
        set_length(5'($urandom_range(0, LAST_LEN)));
      for (j = 0; j < PHASE_ITEMS; j++) begin
        case ($urandom_range(0, 9))
          0:       send_message('1);
          1:       send_message('0);
          default: send_message(rand_msg());
        endcase
      end
    end
  endtask

  // Receiver: one out_tready update per step, held until the next step.
  initial begin : sink
    int n;
    forever begin
      if (hold_req != 0) begin
        n          = hold_req;
        hold_req   = 0;
        out_tready <= 1'b0;
      end else if (sink_idle_en && $urandom_range(0, 7) == 0) begin
        n          = $urandom_range(1, 17);
        out_tready <= 1'b0;
      end else begin
        n          = 1;
        out_tready <= 1'b1;
      end
      repeat (n) @(posedge clk);
    end
  end

  // Result checker: every accepted transaction against the oldest digest.
  always @(posedge clk) begin : digest_check
    logic [159:0] exp_digest;
    if (rst_n && out_tvalid && out_tready) begin
      if (digest_q.size() == 0) begin
        fail_cnt++;
        if (mismatch_cnt++ < 10)
          $display("%0t: digest %h with none expected", $realtime, out_tdata);
      end else begin
        exp_digest = digest_q.pop_front();
        for (int i = 0; i < 5; i++) begin
          if (out_tdata[32*i +: 32] !== exp_digest[32*i +: 32]) begin
            fail_cnt++;
            if (mismatch_cnt++ < 10)
              $display("%0t: digest_h%0d expected %h actual %h", $realtime, i,
                       exp_digest[32*i +: 32], out_tdata[32*i +: 32]);
          end
        end
      end
    end
  end

  initial begin : main
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_length();
    test_length_extremes();
    test_saturation();
    test_backpressure();
    test_random_lengths();

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_cnt == 0 && digest_q.size() == 0) begin
      $display("sha1_short_message_hash test passed");
    end else begin
      $display("sha1_short_message_hash test failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/sha1h_pkg.sv
design/sha1_short_message_hash.sv
sim/sha1_short_message_hash_tb.sv
